// File: hw/rtl/snf_pkg.sv
// Package for the 8.3 short name formatter.
// Holds the character constants, the name phase type and the upcase helper.
// Depends on nothing; imported by the formatter and its checker.
package snf_pkg;

  localparam int unsigned NameLen = 11;
  localparam int unsigned BaseLen = 8;
  localparam int unsigned SlotW   = 4;

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] DotChar   = 8'h2e;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7a;
  localparam logic [7:0] CaseDiff  = 8'h20;
  localparam logic [7:0] TermChar  = 8'h00;

  localparam logic [SlotW-1:0] BaseLenSlot = SlotW'(BaseLen);
  localparam logic [SlotW-1:0] NameLenSlot = SlotW'(NameLen);
  localparam logic [SlotW-1:0] LastSlot    = SlotW'(NameLen - 1);

  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_SKIP = 2'd1,
    PH_EXT  = 2'd2
  } phase_e;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LowerA && c <= LowerZ) begin
      r = c - CaseDiff;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/short_name_formatter.sv
// A terminator item is registered in the input register, then loaded into the output
// buffer; its eleven bytes appear on the master side one per cycle when taken.
// Throughput: one name byte per cycle; a terminator stalls only while the
// eleven-byte output buffer from the previous name is still draining.
// Reset (rst_ni low, asynchronous): name state back to spaces, base phase, no output.
// Top level of the 8.3 short name formatter; uses snf_pkg.
module short_name_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] name_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] slot, [15:12] zero
  output logic        m_axis_tlast    // final_byte
);
  import snf_pkg::*;

  // Input register: one item of look-ahead decouples the handshake.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;

  // Working state for the name being collected.
  logic [7:0]       name_buf_q [NameLen];
  logic [7:0]       name_buf_d [NameLen];
  logic [SlotW-1:0] write_pos_q, write_pos_d;
  phase_e           phase_q, phase_d;
  logic [1:0]       dot_count_q, dot_count_d;
  logic             only_dots_q, only_dots_d;

  // Output buffer: shifts toward entry 0 as bytes are taken.
  logic [7:0]       out_buf_q [NameLen];
  logic [7:0]       out_buf_d [NameLen];
  logic [SlotW-1:0] out_idx_q, out_idx_d;
  logic             busy_q, busy_d;

  logic out_fire, out_last_fire, buf_free, is_term, stage_go, in_fire;
  logic [7:0] up_c;
  logic       dot_name;

  assign out_fire      = busy_q && m_axis_tready;
  assign out_last_fire = out_fire && (out_idx_q == LastSlot);
  assign buf_free      = !busy_q || out_last_fire;
  assign is_term       = (in_byte_q == TermChar);
  // A held terminator moves on only once the output buffer can take it.
  assign stage_go      = in_vld_q && (!is_term || buf_free);
  assign s_axis_tready = !in_vld_q || stage_go;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign up_c     = upcase(in_byte_q);
  assign dot_name = only_dots_q && (dot_count_q == 2'd1 || dot_count_q == 2'd2);

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {4'b0000, out_idx_q, out_buf_q[0]};
  assign m_axis_tlast  = (out_idx_q == LastSlot);

  always_comb begin
    in_vld_d = in_fire ? 1'b1 : (stage_go ? 1'b0 : in_vld_q);
  end

  // Name state update and terminator snapshot.
  always_comb begin
    name_buf_d  = name_buf_q;
    write_pos_d = write_pos_q;
    phase_d     = phase_q;
    dot_count_d = dot_count_q;
    only_dots_d = only_dots_q;
    out_buf_d   = out_buf_q;
    out_idx_d   = out_idx_q;
    busy_d      = busy_q;

    // Drain: advance one byte per taken item.
    if (out_fire) begin
      for (int k = 0; k < NameLen - 1; k++) begin
        out_buf_d[k] = out_buf_q[k+1];
      end
      out_buf_d[NameLen-1] = SpaceChar;
      out_idx_d = out_idx_q + 1'b1;
      if (out_last_fire) begin
        busy_d = 1'b0;
      end
    end

    if (stage_go) begin
      if (!is_term) begin
        if (in_byte_q != DotChar) begin
          only_dots_d = 1'b0;
        end
        if (dot_count_q != 2'd3) begin
          dot_count_d = dot_count_q + 2'd1;
        end
        case (phase_q)
          PH_BASE, PH_SKIP: begin
            if (in_byte_q == DotChar) begin
              phase_d     = PH_EXT;
              write_pos_d = BaseLenSlot;
            end else if (phase_q == PH_BASE && write_pos_q < BaseLenSlot) begin
              name_buf_d[write_pos_q] = up_c;
              write_pos_d = write_pos_q + 1'b1;
              if (write_pos_q + 1'b1 >= BaseLenSlot) begin
                phase_d = PH_SKIP;
              end
            end
          end
          default: begin
            if (write_pos_q >= BaseLenSlot && write_pos_q < NameLenSlot) begin
              name_buf_d[write_pos_q] = up_c;
              write_pos_d = write_pos_q + 1'b1;
            end
          end
        endcase
      end else begin
        // Load the finished name, "." and ".." override the buffer.
        for (int k = 0; k < NameLen; k++) begin
          out_buf_d[k] = dot_name ? SpaceChar : name_buf_q[k];
        end
        if (dot_name) begin
          out_buf_d[0] = DotChar;
          if (dot_count_q == 2'd2) begin
            out_buf_d[1] = DotChar;
          end
        end
        out_idx_d = '0;
        busy_d    = 1'b1;
        // Drop back to the empty name.
        for (int k = 0; k < NameLen; k++) begin
          name_buf_d[k] = SpaceChar;
        end
        write_pos_d = '0;
        phase_d     = PH_BASE;
        dot_count_d = 2'd0;
        only_dots_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      write_pos_q <= '0;
      phase_q     <= PH_BASE;
      dot_count_q <= 2'd0;
      only_dots_q <= 1'b1;
      out_idx_q   <= '0;
      busy_q      <= 1'b0;
      for (int k = 0; k < NameLen; k++) begin
        name_buf_q[k] <= SpaceChar;
      end
    end else begin
      in_vld_q    <= in_vld_d;
      write_pos_q <= write_pos_d;
      phase_q     <= phase_d;
      dot_count_q <= dot_count_d;
      only_dots_q <= only_dots_d;
      out_idx_q   <= out_idx_d;
      busy_q      <= busy_d;
      name_buf_q  <= name_buf_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
    end
    out_buf_q <= out_buf_d;
  end

endmodule

// File: hw/rtl/snf_checker.sv
// Port-level checker for the short name formatter, bound to the top level.
// Depends on snf_pkg and short_name_formatter.
module snf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import snf_pkg::*;

  logic [SlotW-1:0] slot;
  assign slot = m_axis_tdata[11:8];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (slot == LastSlot)) && slot <= LastSlot)
    else $error("tlast does not match the final slot");

  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && slot == $past(slot) + 1'b1)
    else $error("burst broke off or skipped a slot");

  a_new_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid || slot == '0)
    else $error("new name does not start at slot zero");

endmodule

bind short_name_formatter snf_checker u_snf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
